// ===== sv/assert_macros.svh =====
// Assertion macros used by the decoder controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion that is disabled while reset is low
`define BDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle implication
`define BDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/bdt_pkg.sv =====
// Package: constants, types and the GCR table of the telemetry decoder
`timescale 1ns / 1ps
package bdt_pkg;
    localparam int CAPTURE_LENGTH_DEF = 240;
    localparam int RESP_BITS  = 21;
    localparam int DIV_W      = 32;
    localparam int WINDOW_BITS = 24;
    localparam logic [RESP_BITS-1:0] RESP_MASK = 21'h1FFFFF;
    localparam logic [DIV_W-1:0] RPM_NUMER = 32'd60000000;
    localparam logic [DIV_W-1:0] RPM_MAX   = 32'd10000000;

    localparam logic [1:0] REG_PIN_INDEX = 2'd0;
    localparam logic [1:0] REG_SAMPLES   = 2'd1;
    localparam logic [1:0] REG_POLES     = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_EDGE  = 3'd1;
    localparam logic [2:0] ST_BAD_GCR  = 3'd2;
    localparam logic [2:0] ST_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_MALFORM  = 3'd4;

    typedef struct packed {
        logic accept;
        logic run_start;
        logic run_apply;
        logic fin_decode;
        logic div1_start;
        logic div2_start;
        logic rpm_load;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_run;
        logic div_done;
        logic div_busy;
        logic fin_rpm;
        logic out_busy;
    } t_dp_sts;

    // returns {bad, nibble}
    function automatic logic [4:0] gcr_lookup(input logic [4:0] sym);
        logic [4:0] res;
        unique case (sym)
            5'h09: res = {1'b0, 4'd9};
            5'h0A: res = {1'b0, 4'd10};
            5'h0B: res = {1'b0, 4'd11};
            5'h0D: res = {1'b0, 4'd13};
            5'h0E: res = {1'b0, 4'd14};
            5'h0F: res = {1'b0, 4'd15};
            5'h12: res = {1'b0, 4'd2};
            5'h13: res = {1'b0, 4'd3};
            5'h15: res = {1'b0, 4'd5};
            5'h16: res = {1'b0, 4'd6};
            5'h17: res = {1'b0, 4'd7};
            5'h19: res = {1'b0, 4'd0};
            5'h1A: res = {1'b0, 4'd8};
            5'h1B: res = {1'b0, 4'd1};
            5'h1D: res = {1'b0, 4'd4};
            5'h1E: res = {1'b0, 4'd12};
            default: res = {1'b1, 4'd0};
        endcase
        return res;
    endfunction
endpackage

// ===== sv/bidir_dshot_telemetry_decoder_core.sv =====
// Top level of the bidirectional DShot eRPM telemetry decoder
// A sample without a level change is accepted at once; one that closes a run stalls
// the input for the 32-step run-length divider. A marked last sample is followed by
// decode, two 32-step speed divisions for a valid frame, and the result transfer.
// Throughput: one sample per cycle while no run or frame is being closed.
// Reset: synchronous active-low; clears capture state and loads default registers.
`timescale 1ns / 1ps
module bidir_dshot_telemetry_decoder_core #(
    parameter int CAPTURE_LENGTH = bdt_pkg::CAPTURE_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // port_word
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // speed_rpm[23:0], telemetry_word, status, pad
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);
    import bdt_pkg::*;
    t_dp_cmd cmd;
    t_dp_sts sts;

    bdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .i_in_tlast  (s_axis_tlast),
        .o_in_tready (s_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bdt_dp #(.CAPTURE_LENGTH(CAPTURE_LENGTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_port_word  (s_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_tready (m_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_out_tdata  (m_axis_tdata)
    );
endmodule

// ===== sv/bdt_div.sv =====
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bdt_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bdt_pkg::DIV_W-1:0] i_dividend,
    input  logic [bdt_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic                      o_done,
    output logic [bdt_pkg::DIV_W-1:0] o_quotient
);
    import bdt_pkg::*;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo, r_dsr;
    logic [DIV_W:0]   rem_sh, rem_sub;

    assign rem_sh  = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                if (!rem_sub[DIV_W]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== sv/bdt_dp.sv =====
// Datapath: capture state, run accumulation, frame decode, output register
`timescale 1ns / 1ps
module bdt_dp #(
    parameter int CAPTURE_LENGTH = bdt_pkg::CAPTURE_LENGTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdt_pkg::t_dp_cmd i_cmd,
    output bdt_pkg::t_dp_sts o_sts,
    input  logic [15:0]      i_port_word,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_addr,
    input  logic [6:0]       i_cfg_wdata,
    input  logic             i_out_tready,
    output logic             o_out_tvalid,
    output logic [47:0]      o_out_tdata
);
    import bdt_pkg::*;
    localparam int IDX_W = $clog2(CAPTURE_LENGTH + 1);
    localparam int END_W = IDX_W + 9;
    localparam int LEN_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] CAP = IDX_W'(CAPTURE_LENGTH);

    logic [3:0] r_pin, r_spb;
    logic [6:0] r_poles;
    logic [IDX_W-1:0] r_idx, r_last_idx, r_wend, r_pend_idx;
    logic r_edge, r_prev, r_pend_lvl, r_ovf;
    logic [RESP_BITS-1:0] r_resp;
    logic [4:0] r_bcnt;
    logic [23:0] r_rpm;
    logic [15:0] r_word;
    logic [2:0]  r_status;
    logic r_ovalid;
    logic [47:0] r_odata;

    logic level, in_cap;
    logic [3:0] spb;
    logic [6:0] poles;
    logic [END_W-1:0] wend_raw;
    logic div_start, div_busy, div_done;
    logic [DIV_W-1:0] div_a, div_b, div_q;
    logic [LEN_W-1:0] len;
    logic [LEN_W:0] bsum;
    logic [RESP_BITS-1:0] run_resp, run_ones;
    logic [RESP_BITS-1:0] fresp, gcr;
    logic [4:0] g0, g1, g2, g3;
    logic [15:0] dword;
    logic gbad, chk_ok;
    logic [15:0] period;

    assign level    = i_port_word[r_pin];
    assign in_cap   = r_idx < CAP;
    assign spb      = (r_spb == 4'd0) ? 4'd1 : r_spb;
    assign poles    = (r_poles == 7'd0) ? 7'd1 : r_poles;
    assign wend_raw = END_W'(r_idx) + END_W'(spb) * END_W'(WINDOW_BITS);

    // run length and GCR decode
    assign len  = div_q[LEN_W-1:0];
    assign bsum = (LEN_W+1)'(r_bcnt) + (LEN_W+1)'(len);
    always_comb begin
        run_ones = RESP_MASK >> (5'd21 - len[4:0]);
        run_resp = r_resp << len[4:0];
        if (len >= LEN_W'(RESP_BITS)) begin
            run_ones = RESP_MASK;
            run_resp = '0;
        end
        if (r_prev) run_resp = run_resp | run_ones;
    end

    assign fresp = (r_resp << (5'd21 - r_bcnt)) | (RESP_MASK >> r_bcnt);
    assign gcr   = fresp ^ (fresp >> 1);
    assign g0    = gcr_lookup(gcr[4:0]);
    assign g1    = gcr_lookup(gcr[9:5]);
    assign g2    = gcr_lookup(gcr[14:10]);
    assign g3    = gcr_lookup(gcr[19:15]);
    assign gbad  = g0[4] | g1[4] | g2[4] | g3[4];
    assign dword = {g3[3:0], g2[3:0], g1[3:0], g0[3:0]};
    assign chk_ok = (dword[3:0] ^ dword[7:4] ^ dword[11:8] ^ dword[15:12]) == 4'hF;
    assign period = {7'd0, dword[12:4]} << dword[15:13];

    // shared divider
    assign div_start = i_cmd.run_start | i_cmd.div1_start | i_cmd.div2_start;
    always_comb begin
        div_a = DIV_W'({r_idx - r_last_idx, 1'b0}) + DIV_W'(spb);
        div_b = DIV_W'({spb, 1'b0});
        if (i_cmd.div1_start) begin
            div_a = RPM_NUMER;
            div_b = DIV_W'(period);
        end else if (i_cmd.div2_start) begin
            div_a = {div_q[DIV_W-2:0], 1'b0};
            div_b = DIV_W'(poles);
        end
    end

    bdt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin      <= 4'd0;
            r_spb      <= 4'd3;
            r_poles    <= 7'd12;
            r_idx      <= '0;
            r_edge     <= 1'b0;
            r_prev     <= 1'b1;
            r_last_idx <= '0;
            r_wend     <= '0;
            r_resp     <= '0;
            r_bcnt     <= '0;
            r_ovf      <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PIN_INDEX: r_pin   <= i_cfg_wdata[3:0];
                    REG_SAMPLES:   r_spb   <= i_cfg_wdata[3:0];
                    REG_POLES:     r_poles <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.accept && in_cap) begin
                r_idx <= r_idx + 1'b1;
                if (!r_edge && !level) begin
                    r_edge     <= 1'b1;
                    r_prev     <= 1'b0;
                    r_last_idx <= r_idx;
                    r_wend     <= (wend_raw > END_W'(CAP)) ? CAP : wend_raw[IDX_W-1:0];
                end
            end
            if (i_cmd.run_start) begin
                r_pend_idx <= r_idx;
                r_pend_lvl <= level;
            end
            if (i_cmd.run_apply) begin
                r_resp     <= run_resp;
                r_prev     <= r_pend_lvl;
                r_last_idx <= r_pend_idx;
                if (bsum > (LEN_W+1)'(RESP_BITS)) r_ovf <= 1'b1;
                r_bcnt <= (bsum > (LEN_W+1)'(31)) ? 5'd31 : bsum[4:0];
            end
            if (i_cmd.fin_decode) begin
                r_rpm <= '0;
                if (!r_edge) begin
                    r_word <= '0; r_status <= ST_NO_EDGE;
                end else if (r_ovf) begin
                    r_word <= '0; r_status <= ST_MALFORM;
                end else if (gbad) begin
                    r_word <= '0; r_status <= ST_BAD_GCR;
                end else if (!chk_ok) begin
                    r_word <= dword; r_status <= ST_CHECKSUM;
                end else if (period == 16'd0) begin
                    r_word <= dword; r_status <= ST_MALFORM;
                end else begin
                    r_word <= dword; r_status <= ST_OK;
                end
            end
            if (i_cmd.rpm_load)
                r_rpm <= (div_q > RPM_MAX) ? RPM_MAX[23:0] : div_q[23:0];
            if (i_cmd.out_load) begin
                r_ovalid   <= 1'b1;
                r_odata    <= {5'd0, r_status, r_word, r_rpm};
                r_idx      <= '0;
                r_edge     <= 1'b0;
                r_prev     <= 1'b1;
                r_last_idx <= '0;
                r_wend     <= '0;
                r_resp     <= '0;
                r_bcnt     <= '0;
                r_ovf      <= 1'b0;
            end else if (r_ovalid && i_out_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.need_run = in_cap && r_edge && (r_idx < r_wend) && (level != r_prev);
    assign o_sts.div_done = div_done;
    assign o_sts.div_busy = div_busy;
    assign o_sts.fin_rpm  = (r_status == ST_OK);
    assign o_sts.out_busy = r_ovalid && !i_out_tready;
    assign o_out_tvalid   = r_ovalid;
    assign o_out_tdata    = r_odata;
endmodule

// ===== sv/bdt_ctrl.sv =====
// Controller: sequences capture, run rounding, decode and speed division
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_tvalid,
    input  logic             i_in_tlast,
    output logic             o_in_tready,
    output bdt_pkg::t_dp_cmd o_cmd,
    input  bdt_pkg::t_dp_sts i_sts
);
    import bdt_pkg::*;
    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_FIN, S_DEC, S_DIV1, S_DIV2, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;

    always_comb begin
        o_cmd       = '0;
        o_in_tready = 1'b0;
        n_state     = r_state;
        n_last      = r_last;
        unique case (r_state)
            S_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_last = i_in_tlast;
                    if (i_sts.need_run) begin
                        o_cmd.run_start = 1'b1;
                        n_state = S_RUN;
                    end else if (i_in_tlast) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_RUN: if (i_sts.div_done) begin
                o_cmd.run_apply = 1'b1;
                n_state = r_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                o_cmd.fin_decode = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.fin_rpm) begin
                    o_cmd.div1_start = 1'b1;
                    n_state = S_DIV1;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV1: if (i_sts.div_done) begin
                o_cmd.div2_start = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: if (i_sts.div_done) begin
                o_cmd.rpm_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (!i_sts.out_busy) begin
                o_cmd.out_load = 1'b1;
                n_last  = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
        end
    end

    `BDT_ASSERT(a_div_free, i_clk, i_rst_n, (o_cmd.div1_start |-> !i_sts.div_busy), "divider started while busy")
    `BDT_ASSERT(a_out_free, i_clk, i_rst_n, (o_cmd.out_load |-> !i_sts.out_busy), "output overwritten")
    `BDT_ASSERT_NEXT(a_run_wait, i_clk, i_rst_n, o_cmd.run_start, (r_state == S_RUN && i_sts.div_busy), "run division not pending")
endmodule
